FILE: rtl/core/ookd_pkg.sv
package ookd_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_MIN_HIGH   = 3'd0;
	localparam logic [2:0] REG_SYNC_GAP   = 3'd1;
	localparam logic [2:0] REG_ZERO_GAP   = 3'd2;
	localparam logic [2:0] REG_ONE_GAP    = 3'd3;
	localparam logic [2:0] REG_SILENCE    = 3'd4;
	localparam logic [2:0] REG_MIN_REPEAT = 3'd5;
	localparam logic [2:0] REG_MIN_BITS   = 3'd6;

	localparam logic [15:0] RST_MIN_HIGH   = 16'd180;
	localparam logic [15:0] RST_SYNC_GAP   = 16'd3000;
	localparam logic [15:0] RST_ZERO_GAP   = 16'd400;
	localparam logic [15:0] RST_ONE_GAP    = 16'd1500;
	localparam logic [19:0] RST_SILENCE    = 20'd10000;
	localparam logic [7:0]  RST_MIN_REPEAT = 8'd3;
	localparam logic [5:0]  RST_MIN_BITS   = 6'd24;

	typedef struct packed {
		logic        level;
		logic [31:0] now_us;
	} ookd_in_t;

	typedef struct packed {
		logic       frame_done;
		logic [5:0] frame_bits;
		logic [7:0] byte_value;
		logic       last;
	} ookd_out_t;

	typedef struct packed {
		logic [15:0] min_high_us;
		logic [15:0] sync_gap_us;
		logic [15:0] zero_gap_us;
		logic [15:0] one_gap_us;
		logic [19:0] silence_us;
		logic [7:0]  min_repeats;
		logic [5:0]  min_frame_bits;
	} ookd_cfg_t;

	typedef struct packed {
		logic       report;
		logic [5:0] frame_bits;
	} ookd_evt_t;

endpackage

FILE: rtl/core/ookd_cfg_regs.sv
module ookd_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ookd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ookd_pkg::ookd_cfg_t        cfg
);

	ookd_pkg::ookd_cfg_t cfg_q;
	logic                wr_en;
	logic [2:0]          reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_high_us    <= ookd_pkg::RST_MIN_HIGH;
			cfg_q.sync_gap_us    <= ookd_pkg::RST_SYNC_GAP;
			cfg_q.zero_gap_us    <= ookd_pkg::RST_ZERO_GAP;
			cfg_q.one_gap_us     <= ookd_pkg::RST_ONE_GAP;
			cfg_q.silence_us     <= ookd_pkg::RST_SILENCE;
			cfg_q.min_repeats    <= ookd_pkg::RST_MIN_REPEAT;
			cfg_q.min_frame_bits <= ookd_pkg::RST_MIN_BITS;
		end else if (wr_en) begin
			unique case (reg_idx)
				ookd_pkg::REG_MIN_HIGH:   cfg_q.min_high_us    <= pwdata[15:0];
				ookd_pkg::REG_SYNC_GAP:   cfg_q.sync_gap_us    <= pwdata[15:0];
				ookd_pkg::REG_ZERO_GAP:   cfg_q.zero_gap_us    <= pwdata[15:0];
				ookd_pkg::REG_ONE_GAP:    cfg_q.one_gap_us     <= pwdata[15:0];
				ookd_pkg::REG_SILENCE:    cfg_q.silence_us     <= pwdata[19:0];
				ookd_pkg::REG_MIN_REPEAT: cfg_q.min_repeats    <= pwdata[7:0];
				ookd_pkg::REG_MIN_BITS:   cfg_q.min_frame_bits <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ookd_pkg::REG_MIN_HIGH:   prdata = 32'(cfg_q.min_high_us);
			ookd_pkg::REG_SYNC_GAP:   prdata = 32'(cfg_q.sync_gap_us);
			ookd_pkg::REG_ZERO_GAP:   prdata = 32'(cfg_q.zero_gap_us);
			ookd_pkg::REG_ONE_GAP:    prdata = 32'(cfg_q.one_gap_us);
			ookd_pkg::REG_SILENCE:    prdata = 32'(cfg_q.silence_us);
			ookd_pkg::REG_MIN_REPEAT: prdata = 32'(cfg_q.min_repeats);
			ookd_pkg::REG_MIN_BITS:   prdata = 32'(cfg_q.min_frame_bits);
			default:                  prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/ookd_frame_core.sv
module ookd_frame_core #(
	parameter int DATA_BYTES = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  ookd_pkg::ookd_in_t           sample,
	input  ookd_pkg::ookd_cfg_t          cfg,
	output ookd_pkg::ookd_evt_t          evt,
	output logic [DATA_BYTES-1:0][7:0]   saved
);

	localparam int CW = $clog2(8 * DATA_BYTES + 1);
	localparam int IW = $clog2(DATA_BYTES);
	localparam logic [CW-1:0] BIT_LIMIT = CW'(8 * DATA_BYTES);

	logic                       prev_level_q;
	logic [31:0]                high_start_q;
	logic                       high_armed_q;
	logic [31:0]                last_end_q;
	logic [31:0]                prior_end_q;
	logic                       pending_q;
	logic [CW-1:0]              bit_cnt_q;
	logic [DATA_BYTES-1:0][7:0] work_q;
	logic [DATA_BYTES-1:0][7:0] saved_q;
	logic [CW-1:0]              saved_cnt_q;
	logic [7:0]                 repeat_q;

	logic [31:0]                high_start_n;
	logic                       high_armed_n;
	logic [31:0]                last_end_n;
	logic [31:0]                prior_end_n;
	logic                       pending_n;
	logic [CW-1:0]              bit_cnt_n;
	logic [DATA_BYTES-1:0][7:0] work_n;
	logic [DATA_BYTES-1:0][7:0] saved_n;
	logic [CW-1:0]              saved_cnt_n;
	logic [7:0]                 repeat_n;

	logic [31:0]                high_len;
	logic [31:0]                quiet;
	logic [31:0]                gap;
	logic                       report;
	logic [CW-1:0]              bit_wrap;
	logic [IW-1:0]              idx;
	logic                       frame_ok;
	logic                       same;
	logic [7:0]                 saved_cnt8;

	always_comb begin
		high_start_n = high_start_q;
		high_armed_n = high_armed_q;
		last_end_n   = last_end_q;
		prior_end_n  = prior_end_q;
		pending_n    = pending_q;
		bit_cnt_n    = bit_cnt_q;
		work_n       = work_q;
		saved_n      = saved_q;
		saved_cnt_n  = saved_cnt_q;
		repeat_n     = repeat_q;

		// edge tracking
		high_len = sample.now_us - high_start_q;
		if (sample.level) begin
			if (!prev_level_q) begin
				high_start_n = sample.now_us;
				high_armed_n = 1'b1;
			end
		end else if (high_armed_q && (high_len > 32'(cfg.min_high_us))) begin
			prior_end_n  = last_end_q;
			last_end_n   = sample.now_us;
			pending_n    = 1'b1;
			high_armed_n = 1'b0;
		end

		quiet  = sample.now_us - last_end_n;
		report = (quiet > 32'(cfg.silence_us)) && (repeat_q > cfg.min_repeats);

		// gap classification
		gap      = last_end_n - prior_end_n;
		bit_wrap = (bit_cnt_q >= BIT_LIMIT) ? '0 : bit_cnt_q;
		idx      = bit_wrap[IW+2:3];
		frame_ok = 8'(bit_wrap) >= 8'(cfg.min_frame_bits);
		same     = (bit_wrap == saved_cnt_q) && (work_q == saved_q);

		if (report) begin
			repeat_n = '0;
		end else if (pending_n) begin
			pending_n = 1'b0;
			if (gap > 32'(cfg.sync_gap_us)) begin
				if (frame_ok) begin
					if (same) begin
						if (repeat_q != 8'hFF) begin
							repeat_n = repeat_q + 8'd1;
						end
					end else begin
						repeat_n    = '0;
						saved_cnt_n = bit_wrap;
						saved_n     = work_q;
					end
				end
				bit_cnt_n = '0;
				work_n    = '0;
			end else if (gap > 32'(cfg.zero_gap_us)) begin
				work_n[idx] = {work_q[idx][6:0], gap > 32'(cfg.one_gap_us)};
				bit_cnt_n   = bit_wrap + CW'(1);
			end else begin
				bit_cnt_n = bit_wrap;
			end
		end

		saved_cnt8     = 8'(saved_cnt_q);
		evt.report     = report;
		evt.frame_bits = saved_cnt8[5:0];
	end

	assign saved = saved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			high_start_q <= '0;
			high_armed_q <= 1'b0;
			last_end_q   <= '0;
			prior_end_q  <= '0;
			pending_q    <= 1'b0;
			bit_cnt_q    <= '0;
			work_q       <= '0;
			saved_q      <= '0;
			saved_cnt_q  <= '0;
			repeat_q     <= '0;
		end else if (step) begin
			prev_level_q <= sample.level;
			high_start_q <= high_start_n;
			high_armed_q <= high_armed_n;
			last_end_q   <= last_end_n;
			prior_end_q  <= prior_end_n;
			pending_q    <= pending_n;
			bit_cnt_q    <= bit_cnt_n;
			work_q       <= work_n;
			saved_q      <= saved_n;
			saved_cnt_q  <= saved_cnt_n;
			repeat_q     <= repeat_n;
		end
	end

endmodule

FILE: rtl/core/ookd_result_out.sv
module ookd_result_out #(
	parameter int DATA_BYTES = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  ookd_pkg::ookd_evt_t        evt,
	input  logic [DATA_BYTES-1:0][7:0] saved,
	output logic                       take,
	output logic                       result_valid,
	input  logic                       result_stall,
	output ookd_pkg::ookd_out_t        result
);

	localparam int IW = $clog2(DATA_BYTES);
	localparam logic [IW-1:0] LAST_IDX = IW'(DATA_BYTES - 1);

	logic                out_valid_q;
	ookd_pkg::ookd_out_t out_q;
	logic                busy_q;
	logic [IW-1:0]       idx_q;
	logic                out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign take         = out_free && !busy_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			if (evt.report) begin
				busy_q <= 1'b1;
				idx_q  <= IW'(1);
			end
		end else if (busy_q && out_free) begin
			out_valid_q <= 1'b1;
			idx_q       <= idx_q + IW'(1);
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
		end else if (out_valid_q && !result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (evt.report) begin
				out_q.frame_done <= 1'b1;
				out_q.frame_bits <= evt.frame_bits;
				out_q.byte_value <= saved[0];
				out_q.last       <= 1'b0;
			end else begin
				out_q.frame_done <= 1'b0;
				out_q.frame_bits <= '0;
				out_q.byte_value <= '0;
				out_q.last       <= 1'b1;
			end
		end else if (busy_q && out_free) begin
			out_q.frame_done <= 1'b1;
			out_q.frame_bits <= evt.frame_bits;
			out_q.byte_value <= saved[idx_q];
			out_q.last       <= (idx_q == LAST_IDX);
		end
	end

`ifndef NO_ASSERTIONS
	a_report_first: assert property (@(posedge clk) disable iff (!arst_n)
		step && evt.report |=> out_valid_q && out_q.frame_done && !out_q.last)
		else $error("report did not start with a non-final byte");
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_done && !out_q.last |-> busy_q)
		else $error("non-final report byte with nothing left to send");
	a_busy_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> out_valid_q)
		else $error("report in progress without a held result");
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.frame_done |->
			out_q.last && out_q.byte_value == 8'd0 && out_q.frame_bits == 6'd0)
		else $error("plain result carries report data");
`endif

endmodule

FILE: rtl/core/ook_pulse_distance_decoder_unit.sv
// channel   direction  handshake                   payload
// sample    in         sample_valid / sample_stall  ookd_in_t  (level, now_us)
// result    out        result_valid / result_stall  ookd_out_t (frame_done, frame_bits,
//                                                              byte_value, last)
// config    in         apb psel/penable/pready      min_high_us .. min_frame_bits
//
// a poll waits in the input register and is decoded in the cycle it leaves it,
// so one poll per cycle is taken while results flow out and no frame is being reported.
// a poll that reports a frame gives DATA_BYTES results, one per cycle from the output
// register unless stalled; the input register holds the next poll until the last byte has gone.
// a stalled result holds the output register and, once the input register is full,
// the sample channel. arst_n clears all decoder state and configuration to defaults.
module ook_pulse_distance_decoder_unit #(
	parameter int DATA_BYTES = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  ookd_pkg::ookd_in_t          sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ookd_pkg::ookd_out_t         result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ookd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic                       in_valid_s1;
	ookd_pkg::ookd_in_t         in_s1;
	logic                       take;
	logic                       step;
	ookd_pkg::ookd_cfg_t        cfg;
	ookd_pkg::ookd_evt_t        evt;
	logic [DATA_BYTES-1:0][7:0] saved;

	assign step         = in_valid_s1 && take;
	assign sample_stall = in_valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_valid_s1 || take) begin
			in_valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			in_s1 <= sample;
		end
	end

	ookd_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ookd_frame_core #(
		.DATA_BYTES (DATA_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (in_s1),
		.cfg    (cfg),
		.evt    (evt),
		.saved  (saved)
	);

	ookd_result_out #(
		.DATA_BYTES (DATA_BYTES)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.evt          (evt),
		.saved        (saved),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: verif/ook_pulse_distance_decoder_checker.sv
module ook_pulse_distance_decoder_checker #(
	parameter int DATA_BYTES = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_stall,
	input  ookd_pkg::ookd_in_t          sample,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  ookd_pkg::ookd_out_t         result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ookd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        pready,
	output int                          errors,
	output int                          pending
);

	ookd_pkg::ookd_cfg_t cfg;
	logic                prev_level;
	logic                armed;
	logic                pulse_waiting;
	logic [31:0]         rise_us;
	logic [31:0]         pulse_end_us;
	logic [31:0]         prior_end_us;
	int unsigned         bit_count;
	logic [7:0]          work_bytes [DATA_BYTES];
	logic [7:0]          work_count;
	logic [7:0]          saved_bytes [DATA_BYTES];
	logic [7:0]          saved_count;
	logic [7:0]          repeats;
	ookd_pkg::ookd_out_t decoder_outputs [$];
	ookd_pkg::ookd_out_t head;
	int                  mismatches;
	int                  n;

	task decode_poll(input logic lvl, input logic [31:0] now);
		logic [31:0]         gap;
		int unsigned         idx;
		logic                same;
		ookd_pkg::ookd_out_t r;
		int                  k;
		if (lvl) begin
			if (!prev_level) begin
				rise_us = now;
				armed = 1'b1;
			end
		end else if (armed && ((now - rise_us) > cfg.min_high_us)) begin
			prior_end_us = pulse_end_us;
			pulse_end_us = now;
			pulse_waiting = 1'b1;
			armed = 1'b0;
		end
		prev_level = lvl;

		if (((now - pulse_end_us) > cfg.silence_us) && (repeats > cfg.min_repeats)) begin
			repeats = '0;
			for (k = 0; k < DATA_BYTES; k++) begin
				r.frame_done = 1'b1;
				r.frame_bits = saved_count[5:0];
				r.byte_value = saved_bytes[k];
				r.last = (k == DATA_BYTES - 1);
				decoder_outputs.push_back(r);
			end
		end else begin
			if (pulse_waiting) begin
				gap = pulse_end_us - prior_end_us;
				// counter wraps before the byte index is taken
				if (bit_count >= 8 * DATA_BYTES)
					bit_count = 0;
				idx = bit_count / 8;
				if (gap > cfg.sync_gap_us) begin
					work_count = 8'(bit_count);
					if (bit_count >= cfg.min_frame_bits) begin
						same = (work_count == saved_count);
						for (k = 0; k < DATA_BYTES; k++)
							if (work_bytes[k] != saved_bytes[k])
								same = 1'b0;
						if (same) begin
							if (repeats != 8'hFF)
								repeats++;
						end else begin
							repeats = '0;
							saved_count = work_count;
							for (k = 0; k < DATA_BYTES; k++)
								saved_bytes[k] = work_bytes[k];
						end
					end
					bit_count = 0;
					work_count = '0;
					for (k = 0; k < DATA_BYTES; k++)
						work_bytes[k] = '0;
				end else if (gap > cfg.zero_gap_us) begin
					if (idx < DATA_BYTES)
						work_bytes[idx] = {work_bytes[idx][6:0], gap > cfg.one_gap_us};
					bit_count++;
				end
				pulse_waiting = 1'b0;
			end
			r = '0;
			r.last = 1'b1;
			decoder_outputs.push_back(r);
		end
	endtask

	task check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.min_high_us = ookd_pkg::RST_MIN_HIGH;
			cfg.sync_gap_us = ookd_pkg::RST_SYNC_GAP;
			cfg.zero_gap_us = ookd_pkg::RST_ZERO_GAP;
			cfg.one_gap_us = ookd_pkg::RST_ONE_GAP;
			cfg.silence_us = ookd_pkg::RST_SILENCE;
			cfg.min_repeats = ookd_pkg::RST_MIN_REPEAT;
			cfg.min_frame_bits = ookd_pkg::RST_MIN_BITS;
			prev_level = 1'b0;
			armed = 1'b0;
			pulse_waiting = 1'b0;
			rise_us = '0;
			pulse_end_us = '0;
			prior_end_us = '0;
			bit_count = 0;
			work_count = '0;
			saved_count = '0;
			repeats = '0;
			for (n = 0; n < DATA_BYTES; n++) begin
				work_bytes[n] = '0;
				saved_bytes[n] = '0;
			end
			decoder_outputs.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ookd_pkg::ADDR_W-1:2])
					ookd_pkg::REG_MIN_HIGH:   cfg.min_high_us = pwdata[15:0];
					ookd_pkg::REG_SYNC_GAP:   cfg.sync_gap_us = pwdata[15:0];
					ookd_pkg::REG_ZERO_GAP:   cfg.zero_gap_us = pwdata[15:0];
					ookd_pkg::REG_ONE_GAP:    cfg.one_gap_us = pwdata[15:0];
					ookd_pkg::REG_SILENCE:    cfg.silence_us = pwdata[19:0];
					ookd_pkg::REG_MIN_REPEAT: cfg.min_repeats = pwdata[7:0];
					ookd_pkg::REG_MIN_BITS:   cfg.min_frame_bits = pwdata[5:0];
					default: ;
				endcase
			end

			if (result_valid && !result_stall) begin
				if (decoder_outputs.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none, got %h", $time, result);
				end else begin
					head = decoder_outputs.pop_front();
					check_field("frame_done", head.frame_done, result.frame_done);
					check_field("frame_bits", head.frame_bits, result.frame_bits);
					check_field("byte_value", head.byte_value, result.byte_value);
					check_field("last", head.last, result.last);
				end
			end

			if (sample_valid && !sample_stall)
				decode_poll(sample.level, sample.now_us);

			errors <= mismatches;
			pending <= decoder_outputs.size();
		end
	end

endmodule

FILE: verif/ook_pulse_distance_decoder_unit_test.sv
module ook_pulse_distance_decoder_unit_test;

	localparam int DATA_BYTES  = 7;
	localparam int CYCLE_LIMIT = 200000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	ookd_pkg::ookd_in_t          sample = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	ookd_pkg::ookd_out_t         result;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [ookd_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	int                          check_errors;
	int                          pending_results;

	ookd_pkg::ookd_in_t          polls_q [$];
	logic                        took = 1'b0;
	int                          burst_left = 1;
	int                          gap_left = 0;
	int                          stall_mode = 0;
	int                          stall_tick = 0;
	int                          cycle_count = 0;
	int                          items = 0;
	ookd_pkg::ookd_cfg_t         cfg;
	logic [31:0]                 t_us = '0;

	ook_pulse_distance_decoder_unit #(.DATA_BYTES(DATA_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	ook_pulse_distance_decoder_checker #(.DATA_BYTES(DATA_BYTES)) watch (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.errors(check_errors),
		.pending(pending_results)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk)
		took = sample_valid && !sample_stall;

	// sender: bursts of polls with idle gaps between them
	always @(negedge clk) begin
		if (!sample_valid || took) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (polls_q.size() != 0) begin
				sample <= polls_q.pop_front();
				sample_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, switching mode now and then
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			stall_tick++;
			if (stall_tick % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	task automatic poll(input logic lvl, input logic [31:0] now);
		ookd_pkg::ookd_in_t p;
		p.level = lvl;
		p.now_us = now;
		polls_q.push_back(p);
		t_us = now;
		items++;
		while (polls_q.size() >= 4)
			@(posedge clk);
	endtask

	task automatic pulse(input logic [31:0] gap);
		logic [31:0] base;
		logic [31:0] hlen;
		base = t_us;
		hlen = cfg.min_high_us + $urandom_range(1, 40);
		// glitch too short to count as a pulse
		if ($urandom_range(0, 5) == 0) begin
			poll(1'b1, base + 5);
			poll(1'b0, base + 9);
		end
		poll(1'b1, base + gap - hlen);
		poll(1'b0, base + gap);
	endtask

	task automatic noise();
		logic [31:0] dt;
		dt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
		poll(1'($urandom_range(0, 1)), t_us + dt);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (polls_q.size() != 0 || sample_valid || pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [63:0]         frame_pat;
		int                  frame_len;
		int                  budget;
		int                  pick;
		int                  ph;
		int                  i;
		int                  len;
		logic                long_due;
		logic                paused;
		ookd_pkg::ookd_cfg_t nc;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: wrapped timestamps, short high phases, boundary high length
		poll(1'b0, 32'h0000_0000);
		poll(1'b1, 32'hFFFF_FF00);
		poll(1'b0, 32'h0000_0010);
		poll(1'b1, 32'h0000_0100);
		poll(1'b0, 32'h0000_0150);
		poll(1'b0, 32'h0000_0300);
		poll(1'b1, 32'h0000_0900);
		poll(1'b0, 32'h0000_0A00);
		poll(1'b1, 32'h0000_1500);
		poll(1'b0, 32'h0000_1600);
		poll(1'b1, 32'h0000_1700);
		poll(1'b0, 32'h0000_17B4);
		poll(1'b0, 32'h0000_17B5);
		poll(1'b1, 32'hFFFF_FFFF);
		poll(1'b0, 32'h0000_0200);
		poll(1'b1, 32'h0000_0300);
		poll(1'b1, 32'h0000_0400);
		poll(1'b0, 32'h0000_0500);
		poll(1'b0, 32'h7FFF_FFFF);
		poll(1'b0, 32'h8000_0000);

		long_due = 1'b1;
		paused = 1'b0;
		for (ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 2) begin
				nc = '0;
			end else if (ph == 4) begin
				nc = '1;
			end else begin
				nc.min_high_us = 16'($urandom_range(10, 150));
				nc.zero_gap_us = nc.min_high_us + 16'($urandom_range(150, 400));
				nc.one_gap_us = nc.zero_gap_us + 16'($urandom_range(100, 600));
				nc.sync_gap_us = nc.one_gap_us + 16'($urandom_range(300, 1500));
				nc.silence_us = 20'(nc.sync_gap_us) + 20'($urandom_range(500, 5000));
				nc.min_repeats = 8'($urandom_range(0, 1));
				nc.min_frame_bits = 6'($urandom_range(0, 6));
			end
			write_reg(ookd_pkg::REG_MIN_HIGH, 32'(nc.min_high_us));
			write_reg(ookd_pkg::REG_SYNC_GAP, 32'(nc.sync_gap_us));
			write_reg(ookd_pkg::REG_ZERO_GAP, 32'(nc.zero_gap_us));
			write_reg(ookd_pkg::REG_ONE_GAP, 32'(nc.one_gap_us));
			write_reg(ookd_pkg::REG_SILENCE, 32'(nc.silence_us));
			write_reg(ookd_pkg::REG_MIN_REPEAT, 32'(nc.min_repeats));
			write_reg(ookd_pkg::REG_MIN_BITS, 32'(nc.min_frame_bits));
			cfg = nc;

			if ($urandom_range(0, 1) == 1)
				t_us = $urandom;
			else
				t_us = 32'(0) - 32'($urandom_range(1, 20000));
			frame_len = $urandom_range(1, 5);
			frame_pat = {$urandom, $urandom};

			if (ph == 2 || ph == 4) begin
				budget = items + 20;
				while (items < budget)
					noise();
			end else begin
				budget = items + 30;
				while (items < budget) begin
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						noise();
					end else if (pick == 1) begin
						frame_len = $urandom_range(1, 5);
						frame_pat = {$urandom, $urandom};
					end else begin
						// one frame runs past the byte store so the bit counter wraps
						len = long_due ? $urandom_range(57, 60) : frame_len;
						long_due = 1'b0;
						pulse(cfg.sync_gap_us + $urandom_range(1, 300));
						for (i = 0; i < len; i++) begin
							if (frame_pat[i])
								pulse(cfg.one_gap_us
									+ $urandom_range(1, cfg.sync_gap_us - cfg.one_gap_us));
							else
								pulse(cfg.zero_gap_us
									+ $urandom_range(1, cfg.one_gap_us - cfg.zero_gap_us));
						end
						if (pick >= 8) begin
							pulse(cfg.sync_gap_us + $urandom_range(1, 300));
							poll(1'b0, t_us + cfg.silence_us + $urandom_range(1, 500));
						end
					end
					if (ph == 1 && !paused && items >= budget - 25) begin
						drain();
						paused = 1'b1;
					end
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (check_errors == 0 && pending_results == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ookd_pkg.sv
rtl/core/ookd_cfg_regs.sv
rtl/core/ookd_frame_core.sv
rtl/core/ookd_result_out.sv
rtl/core/ook_pulse_distance_decoder_unit.sv
verif/ook_pulse_distance_decoder_checker.sv
verif/ook_pulse_distance_decoder_unit_test.sv
